// ===== rtl/ltd_pkg.sv =====
package ltd_pkg;

  typedef enum logic [4:0] {
    TK_NONE   = 5'd0,
    TK_PLUS   = 5'd1,
    TK_MINUS  = 5'd2,
    TK_MULT   = 5'd3,
    TK_DIV    = 5'd4,
    TK_COLON  = 5'd5,
    TK_SEMI   = 5'd6,
    TK_COMMA  = 5'd7,
    TK_LPAREN = 5'd8,
    TK_RPAREN = 5'd9,
    TK_LBRACK = 5'd10,
    TK_RBRACK = 5'd11,
    TK_LBRACE = 5'd12,
    TK_RBRACE = 5'd13,
    TK_SPACE  = 5'd14,
    TK_IDENT  = 5'd15,
    TK_INT    = 5'd16,
    TK_STR    = 5'd17,
    TK_CHAR   = 5'd18,
    TK_LEQ    = 5'd19,
    TK_LSS    = 5'd20,
    TK_GEQ    = 5'd21,
    TK_GRE    = 5'd22,
    TK_EQL    = 5'd23,
    TK_ASSIGN = 5'd24,
    TK_NEQ    = 5'd25
  } tok_kind_t;

  // Character class flags for one byte
  typedef struct packed {
    logic      letter;
    logic      digit;
    logic      word_tail;  // letter, digit or underscore
    logic      str_body;   // legal inside a string constant
    logic      char_body;  // legal as the body of a char constant
    logic      dquote;
    logic      squote;
    logic      lt;
    logic      gt;
    logic      eq;
    logic      bang;
    tok_kind_t single;     // single-character token, or none
  } ltd_class_t;

endpackage

// ===== rtl/ltd_classify.sv =====
module ltd_classify (
  input  logic [7:0]          ch,
  output ltd_pkg::ltd_class_t cls
);

  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_BANG   = 8'd33;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_MULT   = 8'd42;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_DIV    = 8'd47;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_LT     = 8'd60;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_RBRACK = 8'd93;
  localparam logic [7:0] CH_USCORE = 8'd95;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;
  localparam logic [7:0] CH_TILDE  = 8'd126;

  logic is_letter, is_digit, is_space, is_op;

  always_comb begin
    is_letter = (ch inside {[8'd65:8'd90], [8'd97:8'd122]});
    is_digit  = (ch inside {[8'd48:8'd57]});
    is_space  = (ch inside {[8'd9:8'd13], CH_SPACE});
    is_op     = (ch inside {CH_PLUS, CH_MINUS, CH_MULT, CH_DIV});

    cls.letter    = is_letter;
    cls.digit     = is_digit;
    cls.word_tail = is_letter | is_digit | (ch == CH_USCORE);
    cls.str_body  = (ch inside {[CH_HASH:CH_TILDE], CH_SPACE, CH_BANG});
    cls.char_body = is_letter | is_digit | is_op | (ch == CH_USCORE);
    cls.dquote    = (ch == CH_DQUOTE);
    cls.squote    = (ch == CH_SQUOTE);
    cls.lt        = (ch == CH_LT);
    cls.gt        = (ch == CH_GT);
    cls.eq        = (ch == CH_EQ);
    cls.bang      = (ch == CH_BANG);

    case (ch)
      CH_PLUS:   cls.single = ltd_pkg::TK_PLUS;
      CH_MINUS:  cls.single = ltd_pkg::TK_MINUS;
      CH_MULT:   cls.single = ltd_pkg::TK_MULT;
      CH_DIV:    cls.single = ltd_pkg::TK_DIV;
      CH_COLON:  cls.single = ltd_pkg::TK_COLON;
      CH_SEMI:   cls.single = ltd_pkg::TK_SEMI;
      CH_COMMA:  cls.single = ltd_pkg::TK_COMMA;
      CH_LPAREN: cls.single = ltd_pkg::TK_LPAREN;
      CH_RPAREN: cls.single = ltd_pkg::TK_RPAREN;
      CH_LBRACK: cls.single = ltd_pkg::TK_LBRACK;
      CH_RBRACK: cls.single = ltd_pkg::TK_RBRACK;
      CH_LBRACE: cls.single = ltd_pkg::TK_LBRACE;
      CH_RBRACE: cls.single = ltd_pkg::TK_RBRACE;
      default:   cls.single = is_space ? ltd_pkg::TK_SPACE : ltd_pkg::TK_NONE;
    endcase
  end

endmodule

// ===== rtl/ltd_step.sv =====
module ltd_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ltd_pkg::ltd_class_t  cls,
  output ltd_pkg::tok_kind_t   kind,
  output logic                 lex_error,
  output logic                 pushback
);

  typedef enum logic [3:0] {
    ST_INIT   = 4'd0,
    ST_IDENT  = 4'd1,
    ST_INT    = 4'd2,
    ST_STR    = 4'd3,
    ST_CHAR1  = 4'd4,
    ST_CHAR2  = 4'd5,
    ST_LSS    = 4'd6,
    ST_GRE    = 4'd7,
    ST_ASSIGN = 4'd8,
    ST_BANG   = 4'd9,
    ST_TRAP   = 4'd10
  } state_t;

  state_t             state_r, state_nxt;
  ltd_pkg::tok_kind_t kind_r, kind_nxt;
  logic               err_r, err_nxt;
  logic               back_r, back_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = ltd_pkg::TK_NONE;
    err_nxt   = 1'b0;
    back_nxt  = 1'b0;
    case (state_r)
      ST_INIT: begin
        if (cls.letter)      state_nxt = ST_IDENT;
        else if (cls.digit)  state_nxt = ST_INT;
        else if (cls.dquote) state_nxt = ST_STR;
        else if (cls.squote) state_nxt = ST_CHAR1;
        else if (cls.lt)     state_nxt = ST_LSS;
        else if (cls.gt)     state_nxt = ST_GRE;
        else if (cls.eq)     state_nxt = ST_ASSIGN;
        else if (cls.bang)   state_nxt = ST_BANG;
        else                 kind_nxt  = cls.single;
      end
      ST_IDENT: begin
        if (!cls.word_tail) begin
          state_nxt = ST_INIT;
          kind_nxt  = ltd_pkg::TK_IDENT;
          back_nxt  = 1'b1;
        end
      end
      ST_INT: begin
        if (!cls.digit) begin
          state_nxt = ST_INIT;
          kind_nxt  = ltd_pkg::TK_INT;
          back_nxt  = 1'b1;
        end
      end
      ST_STR: begin
        if (cls.str_body) begin
          state_nxt = ST_STR;
        end else if (cls.dquote) begin
          state_nxt = ST_INIT;
          kind_nxt  = ltd_pkg::TK_STR;
        end else begin
          state_nxt = ST_TRAP;
          err_nxt   = 1'b1;
        end
      end
      ST_CHAR1: begin
        if (cls.char_body) begin
          state_nxt = ST_CHAR2;
        end else begin
          state_nxt = ST_TRAP;
          err_nxt   = 1'b1;
        end
      end
      ST_CHAR2: begin
        if (cls.squote) begin
          state_nxt = ST_INIT;
          kind_nxt  = ltd_pkg::TK_CHAR;
        end else begin
          state_nxt = ST_TRAP;
          err_nxt   = 1'b1;
        end
      end
      ST_LSS: begin
        state_nxt = ST_INIT;
        kind_nxt  = cls.eq ? ltd_pkg::TK_LEQ : ltd_pkg::TK_LSS;
        back_nxt  = !cls.eq;
      end
      ST_GRE: begin
        state_nxt = ST_INIT;
        kind_nxt  = cls.eq ? ltd_pkg::TK_GEQ : ltd_pkg::TK_GRE;
        back_nxt  = !cls.eq;
      end
      ST_ASSIGN: begin
        state_nxt = ST_INIT;
        kind_nxt  = cls.eq ? ltd_pkg::TK_EQL : ltd_pkg::TK_ASSIGN;
        back_nxt  = !cls.eq;
      end
      ST_BANG: begin
        if (cls.eq) begin
          state_nxt = ST_INIT;
          kind_nxt  = ltd_pkg::TK_NEQ;
        end else begin
          state_nxt = ST_TRAP;
          err_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_TRAP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      kind_r  <= ltd_pkg::TK_NONE;
      err_r   <= 1'b0;
      back_r  <= 1'b0;
    end else if (load) begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      err_r   <= err_nxt;
      back_r  <= back_nxt;
    end
  end

  assign kind      = kind_r;
  assign lex_error = err_r;
  assign pushback  = back_r;

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (kind_r == ltd_pkg::TK_NONE) && !back_r)
    else $error("error result carries a token or pushback");

  a_back_has_token: assert property (@(posedge clk) disable iff (!rst_n)
    back_r |-> (kind_r != ltd_pkg::TK_NONE))
    else $error("pushback without a token");

  a_err_traps: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (state_r == ST_TRAP))
    else $error("error result without entering the trap");

  // The error result may sit in the result register through a stall
  a_trap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRAP) |=> (state_r == ST_TRAP) && (!err_r || $past(err_r)))
    else $error("scanner left the trap or flagged a second error");

endmodule

// ===== rtl/lexer_token_dfa_core.sv =====
// Character-at-a-time lexical scanner.
// Input channel: one ASCII byte per request on in_ch, taken when in_valid and
// in_ready are both high. Result channel: one result per input request on
// out_token_kind / out_lex_error / out_pushback, taken when out_valid and
// out_ready are both high. Kind 0 means no token completed yet.
// When out_pushback is high the byte ended an ident, int, '<', '>' or '='
// token without being part of it: present the same byte again.
// A byte and then its result are registered. Throughput: one request per
// cycle while out_ready is high; the input register and the scanner state
// with its result register form a two-stage pipeline, and the single
// scanner state register closes the loop from one byte to the next.
// Stall: while out_ready is low the result is held, the byte waiting in the
// input register is held, and in_ready drops once that register is full.
// Reset (rst_n low, synchronous): both stages empty, scanner back to its
// initial state. An illegal byte in a string, char constant or after '!'
// raises out_lex_error once; the scanner then reports nothing until reset.
module lexer_token_dfa_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_token_kind,
  output logic       out_lex_error,
  output logic       out_pushback
);

  logic                in_v_r;
  logic [7:0]          ch_r;
  logic                out_v_r;
  logic                adv;
  ltd_pkg::ltd_class_t cls;
  ltd_pkg::tok_kind_t  kind;

  // Advance the byte into the scanner when the result slot is free or draining
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  // Input register: hold the byte until the scanner takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  // Result valid: set on advance, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  ltd_classify u_classify (
    .ch  (ch_r),
    .cls (cls)
  );

  ltd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .cls       (cls),
    .kind      (kind),
    .lex_error (out_lex_error),
    .pushback  (out_pushback)
  );

  assign out_valid      = out_v_r;
  assign out_token_kind = 5'(kind);

endmodule
